FILE: sv/rtp_pkg.sv
// Shared types and constants for the ringtone text parser.
// Used by rtp_ctrl, rtp_datapath and ringtone_text_parser.
`timescale 1ns / 1ps

package rtp_pkg;

    localparam int DIV_W   = 18;
    localparam int ACC_W   = 16;
    localparam int DUR_W   = 19;

    localparam logic [1:0] CMD_TEXT  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [1:0] KIND_TONE = 2'd0;
    localparam logic [1:0] KIND_REST = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;

    localparam logic [DIV_W-1:0] MINUTE_MS = 18'd60000;

    typedef struct packed {
        logic       defaults_load;
        logic       acc_clear;
        logic       acc_digit;
        logic       acc_load;
        logic       commit_d;
        logic       commit_b;
        logic       oct_load;
        logic       tok_start;
        logic       semi_load;
        logic       semi_inc;
        logic       dot_set;
        logic       poct_load;
        logic       div_whole;
        logic       div_note;
        logic       out_note;
        logic       out_flag;
        logic       out_last;
        logic [1:0] out_kind;
        logic [3:0] digit;
        logic [3:0] semi_val;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } t_dp_sts;

    function automatic logic [3:0] letter_semitone(input logic [7:0] c);
        logic [3:0] s;
        case (c)
            CH_C:    s = 4'd1;
            CH_D:    s = 4'd3;
            CH_E:    s = 4'd5;
            CH_F:    s = 4'd6;
            CH_G:    s = 4'd8;
            CH_A:    s = 4'd10;
            CH_B:    s = 4'd12;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: sv/rtp_datapath.sv
// Datapath of the ringtone text parser: tune settings, token registers,
// shared restoring divider and the result register. Depends on rtp_pkg.
`timescale 1ns / 1ps

module rtp_datapath import rtp_pkg::*; #(
    parameter int NOTE_TABLE_SIZE = 64,
    parameter int OCTAVE_SHIFT    = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_sts       o_sts,
    input  logic          i_stall,
    output logic          o_valid,
    output logic [1:0]    o_kind,
    output logic [5:0]    o_note_index,
    output logic [18:0]   o_duration_ms,
    output logic          o_last
);

    logic [7:0]       r_ddur;
    logic [3:0]       r_doct;
    logic [ACC_W-1:0] r_tempo;
    logic [DIV_W-1:0] r_whole;
    logic [ACC_W-1:0] r_acc;
    logic [3:0]       r_semi;
    logic [3:0]       r_poct;
    logic             r_dot;

    logic             r_div_busy;
    logic             r_div_whole;
    logic [4:0]       r_cnt;
    logic [ACC_W:0]   r_rem;
    logic [DIV_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_quo;
    logic [ACC_W-1:0] r_dsr;

    logic             r_valid;
    logic [1:0]       r_kind;
    logic [5:0]       r_idx;
    logic [DUR_W-1:0] r_dur;
    logic             r_last;

    logic [19:0]       acc_mul;
    logic [ACC_W-1:0]  acc_sat;
    logic [ACC_W-1:0]  note_div;
    logic [ACC_W-1:0]  tempo_new;
    logic [ACC_W:0]    rem_sh;
    logic              q_bit;
    logic [DIV_W-1:0]  q_next;
    logic signed [9:0] scale_off;
    logic signed [9:0] idx_s;
    logic              idx_ok;
    logic [DUR_W-1:0]  dur_val;

    always_comb begin
        acc_mul   = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {16'b0, i_cmd.digit};
        acc_sat   = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[ACC_W-1:0];
        note_div  = (r_acc != '0) ? r_acc : {8'b0, r_ddur};
        // a tempo committed by the header-ending byte feeds the whole-note divide
        tempo_new = (i_cmd.commit_b && r_acc != '0) ? r_acc : r_tempo;
        rem_sh    = {r_rem[ACC_W-1:0], r_dvd[DIV_W-1]};
        q_bit     = rem_sh >= {1'b0, r_dsr};
        q_next    = {r_quo[DIV_W-2:0], q_bit};
        scale_off = $signed({6'b0, r_poct}) + $signed(10'(OCTAVE_SHIFT)) - 10'sd4;
        idx_s     = (scale_off <<< 3) + (scale_off <<< 2) + $signed({6'b0, r_semi});
        idx_ok    = (r_semi != 4'd0) && (idx_s >= 10'sd0)
                    && (idx_s < $signed(10'(NOTE_TABLE_SIZE)));
        dur_val   = {1'b0, r_quo} + (r_dot ? {2'b0, r_quo[DIV_W-1:1]} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ddur     <= 8'd4;
            r_doct     <= 4'd6;
            r_tempo    <= 16'd63;
            r_whole    <= '0;
            r_acc      <= '0;
            r_semi     <= '0;
            r_poct     <= '0;
            r_dot      <= 1'b0;
            r_div_busy <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cmd.defaults_load) begin
                r_ddur  <= 8'd4;
                r_doct  <= 4'd6;
                r_tempo <= 16'd63;
                r_whole <= '0;
                r_acc   <= '0;
                r_semi  <= '0;
                r_poct  <= '0;
                r_dot   <= 1'b0;
            end
            if (i_cmd.commit_d && r_acc != '0) r_ddur <= r_acc[7:0];
            if (i_cmd.commit_b && r_acc != '0) r_tempo <= r_acc;
            if (i_cmd.oct_load) r_doct <= i_cmd.digit;

            if (i_cmd.tok_start) begin
                r_acc  <= '0;
                r_semi <= '0;
                r_dot  <= 1'b0;
                r_poct <= r_doct;
            end
            if (i_cmd.acc_clear) r_acc <= '0;
            if (i_cmd.acc_digit) r_acc <= acc_sat;
            if (i_cmd.acc_load) r_acc <= {12'b0, i_cmd.digit};
            if (i_cmd.semi_load) r_semi <= i_cmd.semi_val;
            if (i_cmd.semi_inc) r_semi <= r_semi + 4'd1;
            if (i_cmd.dot_set) r_dot <= 1'b1;
            if (i_cmd.poct_load) r_poct <= i_cmd.digit;

            // one quotient bit per cycle, MSB first
            if (i_cmd.div_whole || i_cmd.div_note) begin
                r_div_busy  <= 1'b1;
                r_div_whole <= i_cmd.div_whole;
                r_cnt       <= '0;
                r_rem       <= '0;
                r_quo       <= '0;
                r_dvd       <= i_cmd.div_whole ? MINUTE_MS : r_whole;
                r_dsr       <= i_cmd.div_whole ? tempo_new : note_div;
            end else if (r_div_busy) begin
                r_rem <= q_bit ? rem_sh - {1'b0, r_dsr} : rem_sh;
                r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
                r_quo <= q_next;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_W - 1)) begin
                    r_div_busy <= 1'b0;
                    if (r_dsr == '0) r_quo <= '0;
                    if (r_div_whole)
                        r_whole <= (r_dsr == '0) ? '0 : {q_next[DIV_W-3:0], 2'b00};
                end
            end

            if (i_cmd.out_note || i_cmd.out_flag) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_note) begin
            r_kind <= idx_ok ? KIND_TONE : KIND_REST;
            r_idx  <= idx_ok ? idx_s[5:0] : 6'd0;
            r_dur  <= dur_val;
            r_last <= i_cmd.out_last;
        end else if (i_cmd.out_flag) begin
            r_kind <= i_cmd.out_kind;
            r_idx  <= '0;
            r_dur  <= '0;
            r_last <= i_cmd.out_last;
        end
    end

    assign o_sts.div_busy = r_div_busy;
    assign o_sts.out_full = r_valid;
    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_note_index   = r_idx;
    assign o_duration_ms  = r_dur;
    assign o_last         = r_last;

`ifndef SYNTHESIS
    a_idx_tone_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind != KIND_TONE) |-> r_idx == 6'd0)
        else $error("note index set on a non-tone result");
    a_flag_no_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == KIND_END || r_kind == KIND_ERR)) |-> r_dur == '0)
        else $error("duration set on an end or error result");
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !(i_cmd.div_whole || i_cmd.div_note))
        else $error("divider started while busy");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(i_cmd.out_note || i_cmd.out_flag))
        else $error("result register overwritten");
`endif

endmodule

FILE: sv/rtp_ctrl.sv
// Controller of the ringtone text parser: parse phase, byte decode and
// sequencing of divider and result writes. Depends on rtp_pkg.
`timescale 1ns / 1ps

module rtp_ctrl import rtp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_char_code,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_NAME    = 4'd1;
    localparam logic [3:0] PH_HDR     = 4'd2;
    localparam logic [3:0] PH_KEY_D   = 4'd3;
    localparam logic [3:0] PH_KEY_O   = 4'd4;
    localparam logic [3:0] PH_KEY_B   = 4'd5;
    localparam logic [3:0] PH_VAL_D   = 4'd6;
    localparam logic [3:0] PH_VAL_B   = 4'd7;
    localparam logic [3:0] PH_VAL_O   = 4'd8;
    localparam logic [3:0] PH_N_START = 4'd9;
    localparam logic [3:0] PH_N_NUM   = 4'd10;
    localparam logic [3:0] PH_N_LET   = 4'd11;
    localparam logic [3:0] PH_N_SHARP = 4'd12;
    localparam logic [3:0] PH_N_DOT   = 4'd13;
    localparam logic [3:0] PH_N_SCALE = 4'd14;

    localparam logic [2:0] ST_RUN  = 3'd0;
    localparam logic [2:0] ST_DIVW = 3'd1;
    localparam logic [2:0] ST_DIVN = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [3:0] r_phase, n_phase;
    logic [7:0] r_char,  n_char;

    logic       accept;
    logic [7:0] c;
    logic       is_dig;
    logic       run_h;
    logic       run_s;
    logic       emit;
    t_dp_cmd    cmd;

    assign o_stall = !(r_state == ST_RUN && !i_sts.out_full);
    assign accept  = i_valid && !o_stall;
    assign c       = (r_state == ST_RUN) ? i_char_code : r_char;
    assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_char  = r_char;
        cmd     = '0;
        run_h   = 1'b0;
        run_s   = 1'b0;
        emit    = 1'b0;
        cmd.digit    = c[3:0];
        cmd.semi_val = letter_semitone(c);

        case (r_state)
            ST_RUN: begin
                if (accept) begin
                    n_char = i_char_code;
                    case (i_cmd)
                        CMD_START: begin
                            cmd.defaults_load = 1'b1;
                            n_phase = PH_NAME;
                        end
                        CMD_STOP: n_phase = PH_IDLE;
                        CMD_TEXT: begin
                            case (r_phase)
                                PH_NAME: begin
                                    if (c == CH_COLON) begin
                                        n_phase = PH_HDR;
                                    end else if (c == CH_NUL) begin
                                        cmd.out_flag = 1'b1;
                                        cmd.out_kind = KIND_ERR;
                                        cmd.out_last = 1'b1;
                                        n_phase = PH_IDLE;
                                    end
                                end
                                PH_HDR: run_h = 1'b1;
                                PH_KEY_D, PH_KEY_O, PH_KEY_B: begin
                                    if (c == CH_EQ) begin
                                        cmd.acc_clear = 1'b1;
                                        n_phase = (r_phase == PH_KEY_D) ? PH_VAL_D :
                                                  (r_phase == PH_KEY_O) ? PH_VAL_O : PH_VAL_B;
                                    end else begin
                                        run_h = 1'b1;
                                    end
                                end
                                PH_VAL_D, PH_VAL_B: begin
                                    if (is_dig) begin
                                        cmd.acc_digit = 1'b1;
                                    end else begin
                                        cmd.commit_d  = (r_phase == PH_VAL_D);
                                        cmd.commit_b  = (r_phase == PH_VAL_B);
                                        cmd.acc_clear = 1'b1;
                                        run_h = 1'b1;
                                    end
                                end
                                PH_VAL_O: begin
                                    if (is_dig) begin
                                        cmd.oct_load = 1'b1;
                                        n_phase = PH_HDR;
                                    end else begin
                                        run_h = 1'b1;
                                    end
                                end
                                PH_N_START: run_s = 1'b1;
                                PH_N_NUM: begin
                                    if (is_dig) begin
                                        cmd.acc_digit = 1'b1;
                                    end else begin
                                        cmd.semi_load = 1'b1;
                                        if (c == CH_NUL) emit = 1'b1;
                                        else n_phase = PH_N_LET;
                                    end
                                end
                                PH_N_LET: begin
                                    if (c == CH_SHARP) begin
                                        cmd.semi_inc = 1'b1;
                                        n_phase = PH_N_SHARP;
                                    end else if (c == CH_DOT) begin
                                        cmd.dot_set = 1'b1;
                                        n_phase = PH_N_DOT;
                                    end else if (is_dig) begin
                                        cmd.poct_load = 1'b1;
                                        n_phase = PH_N_SCALE;
                                    end else begin
                                        emit = 1'b1;
                                    end
                                end
                                PH_N_SHARP: begin
                                    if (c == CH_DOT) begin
                                        cmd.dot_set = 1'b1;
                                        n_phase = PH_N_DOT;
                                    end else if (is_dig) begin
                                        cmd.poct_load = 1'b1;
                                        n_phase = PH_N_SCALE;
                                    end else begin
                                        emit = 1'b1;
                                    end
                                end
                                PH_N_DOT: begin
                                    if (is_dig) begin
                                        cmd.poct_load = 1'b1;
                                        n_phase = PH_N_SCALE;
                                    end else begin
                                        emit = 1'b1;
                                    end
                                end
                                PH_N_SCALE: emit = 1'b1;
                                default: n_phase = PH_IDLE;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIVW: if (!i_sts.div_busy) n_state = ST_RUN;
            ST_DIVN: if (!i_sts.div_busy) n_state = ST_EMIT;
            ST_EMIT: begin
                if (!i_sts.out_full) begin
                    cmd.out_note = 1'b1;
                    cmd.out_last = (r_char != CH_NUL);
                    n_state = ST_RUN;
                    run_s = 1'b1;
                end
            end
            ST_END: begin
                if (!i_sts.out_full) begin
                    cmd.out_flag = 1'b1;
                    cmd.out_kind = KIND_END;
                    cmd.out_last = 1'b1;
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase

        // header byte after any fall-through
        if (run_h) begin
            if (c == CH_COLON) begin
                cmd.div_whole = 1'b1;
                n_phase = PH_N_START;
                n_state = ST_DIVW;
            end else if (c == CH_NUL) begin
                cmd.out_flag = 1'b1;
                cmd.out_kind = KIND_ERR;
                cmd.out_last = 1'b1;
                n_phase = PH_IDLE;
            end else if (c == CH_D) begin
                n_phase = PH_KEY_D;
            end else if (c == CH_O) begin
                n_phase = PH_KEY_O;
            end else if (c == CH_B) begin
                n_phase = PH_KEY_B;
            end else begin
                n_phase = PH_HDR;
            end
        end

        if (emit) begin
            cmd.div_note = 1'b1;
            n_state = ST_DIVN;
        end

        // token start; after a note this replays the byte that ended it
        if (run_s) begin
            if (c == CH_SPACE || c == CH_COMMA) begin
                n_phase = PH_N_START;
            end else if (c == CH_NUL) begin
                n_phase = PH_IDLE;
                if (r_state == ST_RUN) begin
                    cmd.out_flag = 1'b1;
                    cmd.out_kind = KIND_END;
                    cmd.out_last = 1'b1;
                end else begin
                    n_state = ST_END;
                end
            end else begin
                cmd.tok_start = 1'b1;
                if (is_dig) begin
                    cmd.acc_load = 1'b1;
                    n_phase = PH_N_NUM;
                end else begin
                    cmd.semi_load = 1'b1;
                    n_phase = PH_N_LET;
                end
            end
        end
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_phase <= PH_IDLE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

`ifndef SYNTHESIS
    a_div_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.div_whole || cmd.div_note) |=> (r_state == ST_DIVW || r_state == ST_DIVN))
        else $error("divider started without waiting for it");
    a_emit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !i_sts.div_busy)
        else $error("note emitted before divide finished");
    a_stall_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> o_stall)
        else $error("byte taken while a transaction is in progress");
`endif

endmodule

FILE: sv/ringtone_text_parser.sv
// Top level of the ringtone text parser: joins controller and datapath.
// Depends on rtp_pkg, rtp_ctrl and rtp_datapath.
`timescale 1ns / 1ps

// Parses ringtone text one byte per transaction. The byte that ends the
// header and the byte that ends a note token run the shared 18-bit
// restoring divider, one quotient bit per cycle; a note's result is then
// held in the output register, and a tune-end result that follows a note
// adds one more result slot. The input stalls while a byte is being
// worked or a result waits to be taken.
module ringtone_text_parser import rtp_pkg::*; #(
    parameter int NOTE_TABLE_SIZE = 64,
    parameter int OCTAVE_SHIFT    = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [5:0]  o_note_index,
    output logic [18:0] o_duration_ms,
    output logic        o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    rtp_datapath #(
        .NOTE_TABLE_SIZE (NOTE_TABLE_SIZE),
        .OCTAVE_SHIFT    (OCTAVE_SHIFT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_note_index  (o_note_index),
        .o_duration_ms (o_duration_ms),
        .o_last        (o_last)
    );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for ringtone_text_parser: directed table, then random tunes.
// Depends on rtp_pkg and the ringtone_text_parser RTL.
`timescale 1ns / 1ps

module tb;
    import rtp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_NAME, ST_HDR, ST_KEY_D, ST_KEY_O, ST_KEY_B,
        ST_VAL_D, ST_VAL_B, ST_VAL_O, ST_N_START, ST_N_NUM,
        ST_N_LETTER, ST_N_SHARP, ST_N_DOT, ST_N_SCALE
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  note_index;
        logic [18:0] duration_ms;
        logic        last;
    } t_note_out;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic       typed;
        logic [1:0] kind;
    } t_row;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_cmd = CMD_TEXT;
    logic [7:0]  i_char_code = CH_NUL;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid, o_last;
    logic [1:0]  o_kind;
    logic [5:0]  o_note_index;
    logic [18:0] o_duration_ms;

    ringtone_text_parser dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    t_phase      phase;
    logic [7:0]  dflt_dur;
    logic [3:0]  dflt_oct;
    logic [15:0] tempo;
    logic [17:0] whole_ms;
    logic [15:0] accum;
    logic [3:0]  semi;
    logic [3:0]  poct;
    logic        dotted;

    t_note_out   note_q[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;

    function automatic logic is_num(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [15:0] acc_next(logic [15:0] a, logic [7:0] c);
        int v;
        v = a * 10 + (c - CH_ZERO);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [3:0] semi_of(logic [7:0] c);
        case (c)
            CH_C: return 4'd1;
            CH_D: return 4'd3;
            CH_E: return 4'd5;
            CH_F: return 4'd6;
            CH_G: return 4'd8;
            CH_A: return 4'd10;
            CH_B: return 4'd12;
            default: return 4'd0;
        endcase
    endfunction

    task automatic push_note(logic [1:0] k, logic [5:0] idx, int dur);
        t_note_out r;
        r.kind = k;
        r.note_index = idx;
        r.duration_ms = dur[18:0];
        r.last = 1'b0;
        note_q.push_back(r);
    endtask

    task automatic push_tone_or_rest();
        int divisor, dur, scale, idx;
        divisor = (accum != 0) ? accum : dflt_dur;
        dur = (divisor != 0) ? whole_ms / divisor : 0;
        if (dotted) dur = dur + dur / 2;
        scale = (poct + 256) & 255;
        idx = (scale - 4) * 12 + semi;
        if (semi != 0 && idx >= 0 && idx < 64) push_note(KIND_TONE, idx[5:0], dur);
        else push_note(KIND_REST, 6'd0, dur);
    endtask

    task automatic reset_tune();
        phase = ST_IDLE;
        dflt_dur = 8'd4;
        dflt_oct = 4'd6;
        tempo = 16'd63;
        whole_ms = '0;
        accum = '0;
        semi = '0;
        poct = '0;
        dotted = 1'b0;
    endtask

    task automatic parse_byte(logic [7:0] c);
        bit done;
        done = 0;
        while (!done) begin
            done = 1;
            case (phase)
                ST_NAME: begin
                    if (c == CH_COLON) phase = ST_HDR;
                    else if (c == CH_NUL) begin
                        push_note(KIND_ERR, 6'd0, 0);
                        phase = ST_IDLE;
                    end
                end
                ST_HDR: begin
                    if (c == CH_COLON) begin
                        whole_ms = 18'((tempo != 0) ? (60000 / tempo) * 4 : 0);
                        phase = ST_N_START;
                    end else if (c == CH_NUL) begin
                        push_note(KIND_ERR, 6'd0, 0);
                        phase = ST_IDLE;
                    end else if (c == CH_D) phase = ST_KEY_D;
                    else if (c == CH_O) phase = ST_KEY_O;
                    else if (c == CH_B) phase = ST_KEY_B;
                end
                ST_KEY_D, ST_KEY_O, ST_KEY_B: begin
                    if (c == CH_EQ) begin
                        accum = '0;
                        phase = (phase == ST_KEY_D) ? ST_VAL_D :
                                (phase == ST_KEY_O) ? ST_VAL_O : ST_VAL_B;
                    end else begin
                        phase = ST_HDR;
                        done = 0;
                    end
                end
                ST_VAL_D, ST_VAL_B: begin
                    if (is_num(c)) accum = acc_next(accum, c);
                    else begin
                        if (accum != 0) begin
                            if (phase == ST_VAL_D) dflt_dur = accum[7:0];
                            else tempo = accum;
                        end
                        accum = '0;
                        phase = ST_HDR;
                        done = 0;
                    end
                end
                ST_VAL_O: begin
                    phase = ST_HDR;
                    if (is_num(c)) dflt_oct = 4'(c - CH_ZERO);
                    else done = 0;
                end
                ST_N_START: begin
                    if (c == CH_NUL) begin
                        push_note(KIND_END, 6'd0, 0);
                        phase = ST_IDLE;
                    end else if (c != CH_SPACE && c != CH_COMMA) begin
                        accum = '0;
                        semi = '0;
                        dotted = 1'b0;
                        poct = dflt_oct;
                        if (is_num(c)) begin
                            accum = 16'(c - CH_ZERO);
                            phase = ST_N_NUM;
                        end else begin
                            semi = semi_of(c);
                            phase = ST_N_LETTER;
                        end
                    end
                end
                ST_N_NUM: begin
                    if (is_num(c)) accum = acc_next(accum, c);
                    else begin
                        semi = semi_of(c);
                        if (c == CH_NUL) begin
                            phase = ST_N_SCALE;
                            done = 0;
                        end else phase = ST_N_LETTER;
                    end
                end
                ST_N_LETTER: begin
                    phase = ST_N_SHARP;
                    if (c == CH_SHARP) semi = semi + 4'd1;
                    else done = 0;
                end
                ST_N_SHARP: begin
                    phase = ST_N_DOT;
                    if (c == CH_DOT) dotted = 1'b1;
                    else done = 0;
                end
                ST_N_DOT: begin
                    phase = ST_N_SCALE;
                    if (is_num(c)) poct = 4'(c - CH_ZERO);
                    else done = 0;
                end
                ST_N_SCALE: begin
                    push_tone_or_rest();
                    phase = ST_N_START;
                    if (c != CH_COMMA) done = 0;
                end
                default: phase = ST_IDLE;
            endcase
        end
    endtask

    task automatic predict(logic [1:0] cmd, logic [7:0] c);
        int n0;
        n0 = note_q.size();
        if (cmd == CMD_START) begin
            reset_tune();
            phase = ST_NAME;
        end else if (cmd == CMD_STOP) phase = ST_IDLE;
        else if (cmd == CMD_TEXT) parse_byte(c);
        if (note_q.size() > n0) note_q[note_q.size() - 1].last = 1'b1;
    endtask

    // drive one transaction and wait for acceptance
    task automatic send(logic [1:0] cmd, logic [7:0] c);
        while (($urandom % 100) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_char_code <= c;
        predict(cmd, c);
        items_sent++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic pause_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_note_out got, want;
            got = '{o_kind, o_note_index, o_duration_ms, o_last};
            results_seen++;
            if (note_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = note_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) i_stall <= (($urandom % 100) < rcv_idle_pct);

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && idle_cycles > STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // directed table: all rows use the predictor; typed rows carry a kind it must give
    t_row rows[] = '{
        '{CMD_TEXT,  CH_C,     0, 0},
        '{2'd3,      CH_A,     0, 0},
        '{CMD_START, CH_NUL,   0, 0},
        '{CMD_TEXT,  CH_NUL,   1, KIND_ERR},
        '{CMD_START, 8'hFF,    0, 0},
        '{CMD_TEXT,  CH_COLON, 0, 0},
        '{CMD_TEXT,  CH_D,     0, 0},
        '{CMD_TEXT,  CH_EQ,    0, 0},
        '{CMD_TEXT,  CH_NINE,  0, 0},
        '{CMD_TEXT,  CH_NINE,  0, 0},
        '{CMD_TEXT,  CH_NINE,  0, 0},
        '{CMD_TEXT,  CH_NINE,  0, 0},
        '{CMD_TEXT,  CH_NINE,  0, 0},
        '{CMD_TEXT,  CH_NINE,  0, 0},
        '{CMD_TEXT,  CH_O,     0, 0},
        '{CMD_TEXT,  CH_COLON, 0, 0},
        '{CMD_TEXT,  CH_COLON, 0, 0},
        '{CMD_TEXT,  CH_B,     0, 0},
        '{CMD_TEXT,  CH_SHARP, 0, 0},
        '{CMD_TEXT,  CH_DOT,   0, 0},
        '{CMD_TEXT,  CH_ZERO,  0, 0},
        '{CMD_TEXT,  CH_NUL,   0, 0},
        '{CMD_STOP,  CH_NUL,   0, 0}
    };

    function automatic logic [7:0] pick_byte();
        logic [7:0] pool[] = '{CH_A, CH_B, CH_C, CH_D, CH_E, CH_F, CH_G, 8'h70,
                               CH_SHARP, CH_DOT, CH_COMMA, CH_SPACE, CH_COLON};
        case ($urandom % 10)
            0, 1, 2: return 8'(CH_ZERO + ($urandom % 10));
            3:       return 8'($urandom_range(0, 255));
            default: return pool[$urandom % pool.size()];
        endcase
    endfunction

    task automatic send_number(int v);
        string s;
        s.itoa(v);
        for (int k = 0; k < s.len(); k++) send(CMD_TEXT, s[k]);
    endtask

    // one well-formed tune with random content and a little noise
    task automatic send_tune(int notes);
        logic [7:0] keys[] = '{CH_D, CH_O, CH_B};
        logic [7:0] letters[] = '{CH_A, CH_B, CH_C, CH_D, CH_E, CH_F, CH_G, 8'h70};
        int nk;
        send(CMD_START, 8'($urandom));
        repeat ($urandom_range(0, 3)) send(CMD_TEXT, 8'($urandom_range(97, 122)));
        send(CMD_TEXT, CH_COLON);
        nk = $urandom_range(0, 4);
        for (int k = 0; k < nk; k++) begin
            logic [7:0] key;
            key = keys[$urandom % 3];
            send(CMD_TEXT, key);
            if ($urandom % 8 != 0) send(CMD_TEXT, CH_EQ);
            if (key == CH_O) send(CMD_TEXT, 8'(CH_ZERO + $urandom_range(0, 9)));
            else case ($urandom % 6)
                0: send_number(65535 + $urandom_range(0, 9999));
                1: ;
                2: send_number(0);
                default: send_number($urandom_range(1, 300));
            endcase
            send(CMD_TEXT, ($urandom % 2) ? CH_COMMA : pick_byte());
        end
        send(CMD_TEXT, CH_COLON);
        for (int k = 0; k < notes; k++) begin
            if ($urandom % 2) send_number((1 << $urandom_range(0, 5)));
            send(CMD_TEXT, letters[$urandom % letters.size()]);
            if ($urandom % 3 == 0) send(CMD_TEXT, CH_SHARP);
            if ($urandom % 3 == 0) send(CMD_TEXT, CH_DOT);
            if ($urandom % 2) send(CMD_TEXT, 8'(CH_ZERO + $urandom_range(0, 9)));
            if ($urandom % 10 == 0) send(CMD_TEXT, pick_byte());
            else if (k + 1 < notes) send(CMD_TEXT, CH_COMMA);
        end
        case ($urandom % 10)
            0:       send(CMD_STOP, 8'($urandom));
            1:       ;
            default: send(CMD_TEXT, CH_NUL);
        endcase
    endtask

    task automatic run_random(int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom % 8 == 0) begin
                repeat ($urandom_range(1, 6)) send(2'($urandom_range(0, 3)), pick_byte());
            end else send_tune($urandom_range(1, 8));
            if ($urandom % 4 == 0) pause_valid();
        end
    endtask

    initial begin
        reset_tune();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        snd_idle_pct = 14;
        rcv_idle_pct = 58;
        foreach (rows[k]) begin
            if (rows[k].typed) begin
                send(rows[k].cmd, rows[k].ch);
                if (note_q.size() == 0 || note_q[note_q.size() - 1].kind != rows[k].kind) begin
                    mismatches++;
                    $display("table row %0d: predicted kind differs from %0d", k, rows[k].kind);
                end
            end else send(rows[k].cmd, rows[k].ch);
        end
        run_random(560);
        snd_idle_pct = 58;
        rcv_idle_pct = 14;
        run_random(560);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(560);
        i_valid <= 1'b0;
        while (note_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("sent %0d bytes and commands in tunes with random headers and notes", items_sent);
        $display("checked %0d results under three idle patterns", results_seen);
        if (mismatches == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
